// ===== rtl/ssr_pkg.sv =====
// ============================================================================
// ssr_pkg: shared types and constants of the segment spread ratio block
// Field widths, datapath widths of the shift-subtract unit, and the
// sequencer state type.
// ============================================================================
package ssr_pkg;

    // Input and output field widths
    localparam int COORD_W    = 16;
    localparam int RATIO_W    = 17;
    localparam int IN_DATA_W  = 4 * COORD_W;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    // Deviation and square widths
    localparam int DEV_W  = COORD_W + 1;
    localparam int PROD_W = 2 * DEV_W;

    // Sums of squares, roots and the shift-subtract remainder
    localparam int SUM_W      = 48;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = 28;
    localparam int STEP_W     = 6;
    localparam int RATIO_FRAC = 16;

    // Defaults of the top-level parameters
    localparam int DEF_MAX_POINTS      = 1024;
    localparam int DEF_COORD_FRAC_BITS = 10;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ADD_Y,
        ST_CHECK,
        ST_DIV_X,
        ST_SQRT_X,
        ST_DIV_Y,
        ST_SQRT_Y,
        ST_RATIO,
        ST_OUT
    } ssr_state_t;

endpackage

// ===== rtl/segment_spread_ratio.sv =====
// ============================================================================
// segment_spread_ratio: spread ratio of the points of one scan segment
// Sums squared deviations of the points from the segment mean and, on the
// last point, outputs (1 + min std) / (1 + max std) as a Q1.16 ratio.
// ============================================================================
//
//  Channel  | Direction | Signals                     | Content
//  ---------+-----------+-----------------------------+---------------------------
//  s_       | in        | tvalid tready tdata tuser   | one point, first/last flags
//           |           | tlast                       |
//  m_       | out       | tvalid tready tdata tuser   | ratio and status flags
//
//  A point that is not the last passes through accept, two squares through
//  the one shared multiplier and a final add; a point past MAX_POINTS is
//  dropped after accept and the count check. A last point of a segment
//  with three or more points then runs the one shift-subtract unit through
//  two 48-step divisions, two 24-step square roots and a 48-step ratio
//  division, one step per cycle. Segments of at most two points skip the unit.
//  Reset clears the sums, count, held mean and output valid at once.
//  A stalled result holds the block in its output state until it is taken.
//
module segment_spread_ratio
    import ssr_pkg::*;
#(
    parameter int MAX_POINTS      = DEF_MAX_POINTS,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input point
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y, mean_x, mean_y
    input  logic                  s_tuser,   // first_point
    input  logic                  s_tlast,   // last_point
    // Result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // spread_ratio, zero padding
    output logic [OUT_USER_W-1:0] m_tuser    // too_few_points, point_overflow
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam int ONE_W = ROOT_W + 1;
    localparam logic [ONE_W-1:0] ONE_VAL = ONE_W'(1) << COORD_FRAC_BITS;

    // Control registers
    ssr_state_t             state_reg, state_next;
    logic [COORD_W-1:0]     mean_x_reg, mean_x_next;
    logic [COORD_W-1:0]     mean_y_reg, mean_y_next;
    logic [SUM_W-1:0]       sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]       sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   last_reg, last_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload registers
    logic [COORD_W-1:0]     pt_x_reg, pt_x_next;
    logic [COORD_W-1:0]     pt_y_reg, pt_y_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [SUM_W-1:0]       work_reg, work_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [REM_W-1:0]       dvsr_reg, dvsr_next;
    logic [ROOT_W-1:0]      sx_reg, sx_next;
    logic [RATIO_W-1:0]     res_ratio_reg, res_ratio_next;
    logic                   res_few_reg, res_few_next;
    logic [RATIO_W-1:0]     out_ratio_reg, out_ratio_next;
    logic                   out_few_reg, out_few_next;
    logic                   out_ovf_reg, out_ovf_next;

    // Shared multiplier: squared deviation of x or y
    logic                   sel_y;
    logic [COORD_W-1:0]     mul_mean, mul_pt;
    logic [DEV_W-1:0]       dev, dev_abs;
    logic [PROD_W-1:0]      square;

    assign sel_y    = (state_reg == ST_SQ_Y);
    assign mul_mean = sel_y ? mean_y_reg : mean_x_reg;
    assign mul_pt   = sel_y ? pt_y_reg : pt_x_reg;
    assign dev      = {mul_mean[COORD_W-1], mul_mean} - {mul_pt[COORD_W-1], mul_pt};
    assign dev_abs  = dev[DEV_W-1] ? (~dev + DEV_W'(1)) : dev;
    assign square   = PROD_W'(dev_abs) * PROD_W'(dev_abs);

    // Shared shift-subtract unit: one step of a restoring division or root
    logic                   sqrt_mode;
    logic [REM_W-1:0]       r_shift, operand, rem_step;
    logic [REM_W:0]         diff;
    logic                   take;
    logic [SUM_W-1:0]       quo_step, work_step;
    logic                   step_done;

    assign sqrt_mode = (state_reg == ST_SQRT_X) || (state_reg == ST_SQRT_Y);
    assign r_shift   = sqrt_mode ? {rem_reg[REM_W-3:0], work_reg[SUM_W-1:SUM_W-2]}
                                 : {rem_reg[REM_W-2:0], work_reg[SUM_W-1]};
    assign operand   = sqrt_mode ? {quo_reg[REM_W-3:0], 2'b01} : dvsr_reg;
    assign diff      = {1'b0, r_shift} - {1'b0, operand};
    assign take      = !diff[REM_W];
    assign rem_step  = take ? diff[REM_W-1:0] : r_shift;
    assign quo_step  = {quo_reg[SUM_W-2:0], take};
    assign work_step = sqrt_mode ? (work_reg << 2) : (work_reg << 1);
    assign step_done = (step_reg == (sqrt_mode ? STEP_W'(ROOT_W - 1) : STEP_W'(SUM_W - 1)));

    // Divisor count - 1, and min and max of the two roots
    logic [CNT_W-1:0]       count_m1;
    logic [ROOT_W-1:0]      root_y, lo_root, hi_root;
    logic [ONE_W-1:0]       one_lo, one_hi;

    assign count_m1 = count_reg - CNT_W'(1);
    assign root_y   = quo_step[ROOT_W-1:0];
    assign lo_root  = (sx_reg < root_y) ? sx_reg : root_y;
    assign hi_root  = (sx_reg < root_y) ? root_y : sx_reg;
    assign one_lo   = ONE_VAL + {1'b0, lo_root};
    assign one_hi   = ONE_VAL + {1'b0, hi_root};

    // State register and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mean_x_reg    <= '0;
            mean_y_reg    <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mean_x_reg    <= mean_x_next;
            mean_y_reg    <= mean_y_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pt_x_reg      <= pt_x_next;
        pt_y_reg      <= pt_y_next;
        prod_reg      <= prod_next;
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvsr_reg      <= dvsr_next;
        sx_reg        <= sx_next;
        res_ratio_reg <= res_ratio_next;
        res_few_reg   <= res_few_next;
        out_ratio_reg <= out_ratio_next;
        out_few_reg   <= out_few_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        mean_x_next    = mean_x_reg;
        mean_y_next    = mean_y_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        pt_x_next      = pt_x_reg;
        pt_y_next      = pt_y_reg;
        prod_next      = prod_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvsr_next      = dvsr_reg;
        sx_next        = sx_reg;
        res_ratio_next = res_ratio_reg;
        res_few_next   = res_few_reg;
        out_ratio_next = out_ratio_reg;
        out_few_next   = out_few_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;

        // Iterative states advance the shift-subtract unit by one step
        if (state_reg == ST_DIV_X || state_reg == ST_SQRT_X || state_reg == ST_DIV_Y
            || state_reg == ST_SQRT_Y || state_reg == ST_RATIO)
        begin
            rem_next  = rem_step;
            quo_next  = quo_step;
            work_next = work_step;
            step_next = step_reg + STEP_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pt_x_next = s_tdata[COORD_W-1:0];
                    pt_y_next = s_tdata[2*COORD_W-1:COORD_W];
                    last_next = s_tlast;
                    // A first point latches the mean and restarts the sums
                    if (s_tuser)
                    begin
                        mean_x_next = s_tdata[3*COORD_W-1:2*COORD_W];
                        mean_y_next = s_tdata[4*COORD_W-1:3*COORD_W];
                        sum_x_next  = '0;
                        sum_y_next  = '0;
                        count_next  = '0;
                        ovf_next    = 1'b0;
                    end
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X:
            begin
                if (count_reg < CNT_MAX)
                begin
                    prod_next  = square;
                    state_next = ST_SQ_Y;
                end
                else
                begin
                    // Points past the maximum are dropped and flagged
                    ovf_next   = 1'b1;
                    state_next = last_reg ? ST_CHECK : ST_IDLE;
                end
            end
            ST_SQ_Y:
            begin
                sum_x_next = sum_x_reg + SUM_W'(prod_reg);
                prod_next  = square;
                state_next = ST_ADD_Y;
            end
            ST_ADD_Y:
            begin
                sum_y_next = sum_y_reg + SUM_W'(prod_reg);
                count_next = count_reg + CNT_W'(1);
                state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                if (count_reg <= CNT_W'(2))
                begin
                    res_ratio_next = '0;
                    res_few_next   = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    work_next  = sum_x_reg;
                    dvsr_next  = REM_W'(count_m1);
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (step_done)
                begin
                    work_next  = quo_step;
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_SQRT_X;
                end
            end
            ST_SQRT_X:
            begin
                if (step_done)
                begin
                    sx_next    = quo_step[ROOT_W-1:0];
                    work_next  = sum_y_reg;
                    dvsr_next  = REM_W'(count_m1);
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (step_done)
                begin
                    work_next  = quo_step;
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_SQRT_Y;
                end
            end
            ST_SQRT_Y:
            begin
                if (step_done)
                begin
                    // Ratio division: ((one + min) << 16) / (one + max)
                    work_next  = SUM_W'(one_lo) << RATIO_FRAC;
                    dvsr_next  = REM_W'(one_hi);
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_RATIO;
                end
            end
            ST_RATIO:
            begin
                if (step_done)
                begin
                    res_ratio_next = quo_step[RATIO_W-1:0];
                    res_few_next   = 1'b0;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Wait for the output register to free, then clear the sums
                if (!out_valid_reg || m_tready)
                begin
                    out_ratio_next = res_ratio_reg;
                    out_few_next   = res_few_reg;
                    out_ovf_next   = ovf_reg;
                    out_valid_next = 1'b1;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RATIO_W){1'b0}}, out_ratio_reg};
    assign m_tuser  = {out_ovf_reg, out_few_reg};

endmodule

// ===== rtl/ssr_checker.sv =====
// ============================================================================
// ssr_checker: port-level checks of the segment spread ratio block
// Watches the handshakes and result fields of the top level over time.
// ============================================================================
module ssr_checker
    import ssr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [OUT_USER_W-1:0] m_tuser
);

    // A stalled result keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Each accepted point keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("point accepted in back-to-back cycles");

    // A short segment always reports a zero ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[RATIO_W-1:0] == '0)
        else $error("nonzero ratio on a short segment");

    // The ratio never exceeds 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[RATIO_W-1] || m_tdata[RATIO_W-2:0] == '0))
        else $error("ratio above 1.0");

endmodule

bind segment_spread_ratio ssr_checker u_ssr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
